// File: design/bhed_pkg.sv
// Shared types, constants and helpers for the backslash hex escape decoder.
package bhed_pkg;

  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [7:0] X_CHAR         = 8'h78;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX0 = 2'd2,
    PH_HEX1 = 2'd3
  } phase_t;

  // Up to three decoded bytes caused by one input word, first in slot 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_nib = v[3:0];
  endfunction

endpackage

// File: design/bhed_front.sv
// Front end: accept raw bytes, track the escape phase, build result bundles.
module bhed_front
  import bhed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic [2:0][7:0] slot;
  logic [1:0] n;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      held  <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  always_comb begin
    phase_next = phase;
    held_next  = held;
    slot       = '0;
    n          = 2'd0;
    unique case (phase)
      PH_TEXT: begin
        if (in_byte == BACKSLASH_CHAR) begin
          phase_next = PH_ESC;
        end else begin
          slot[0] = in_byte;
          n       = 2'd1;
        end
      end
      PH_ESC: begin
        if (in_byte == X_CHAR) begin
          phase_next = PH_HEX0;
        end else begin
          phase_next = PH_TEXT;
          slot[0]    = in_byte;
          n          = 2'd1;
        end
      end
      PH_HEX0: begin
        if (is_hex(in_byte)) begin
          held_next  = in_byte;
          phase_next = PH_HEX1;
        end else begin
          phase_next = PH_TEXT;
          slot[0]    = X_CHAR;
          n          = 2'd1;
          if (in_byte == BACKSLASH_CHAR) begin
            phase_next = PH_ESC;
          end else begin
            slot[1] = in_byte;
            n       = 2'd2;
          end
        end
      end
      PH_HEX1: begin
        phase_next = PH_TEXT;
        held_next  = 8'h00;
        if (is_hex(in_byte)) begin
          slot[0] = {hex_nib(held), hex_nib(in_byte)};
          n       = 2'd1;
        end else begin
          slot[0] = X_CHAR;
          slot[1] = held;
          n       = 2'd2;
          if (in_byte == BACKSLASH_CHAR) begin
            phase_next = PH_ESC;
          end else begin
            slot[2] = in_byte;
            n       = 2'd3;
          end
        end
      end
      default: begin
        phase_next = PH_TEXT;
      end
    endcase

    // Flush a pending escape at string end; an open backslash is emitted after the
    // word's other output, the 'x' of a hex escape broken before a digit, or 'x' and the digit.
    if (is_last) begin
      unique case (phase_next)
        PH_ESC: begin
          case (n)
            2'd0:    slot[0] = BACKSLASH_CHAR;
            2'd1:    slot[1] = BACKSLASH_CHAR;
            default: slot[2] = BACKSLASH_CHAR;
          endcase
          n = n + 2'd1;
        end
        PH_HEX0: begin
          slot[0] = X_CHAR;
          n       = 2'd1;
        end
        PH_HEX1: begin
          slot[0] = X_CHAR;
          slot[1] = held_next;
          n       = 2'd2;
        end
        default: begin
        end
      endcase
      phase_next = PH_TEXT;
      held_next  = 8'h00;
    end
  end

  assign q_push       = accept && (n != 2'd0);
  assign q_data.bytes = slot;
  assign q_data.count = n;
  assign q_data.last  = is_last;

endmodule

// File: design/bhed_queue.sv
// Short queue of result bundles between front and back.
module bhed_queue
  import bhed_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push, do_pop;

  assign full       = (fill == FULL_CNT);
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: design/bhed_back.sv
// Back end: unpack bundles into single decoded bytes through an output register.
module bhed_back
  import bhed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);

  logic [1:0] idx;
  logic       load, final_slot;
  logic [7:0] sel_byte;

  assign load       = head_valid && (!out_valid || !out_stall);
  assign final_slot = (idx == head.count - 2'd1);
  assign pop        = load && final_slot;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_slot ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= sel_byte;
      run_end    <= final_slot;
      string_end <= final_slot && head.last;
    end
  end

endmodule

// File: design/backslash_hex_escape_decoder.sv
// Top level of the backslash hex escape decoder.
//
// Input channel: one raw byte per word (in_byte) with is_last marking the
// final byte of a string; a word is taken when in_valid is high and in_stall
// is low. Output channel: one decoded byte per word (out_byte), with run_end
// on the last result caused by an input word and string_end on the final
// byte of the string; taken when out_valid is high and out_stall is low.
// Throughput: one input word per cycle while each word yields at most one
// byte and out_stall stays low; the bytes of a word that yields two or three
// leave one at a time, and the queue between front and back absorbs short bursts.
// Each result bundle is written into the queue at the accepting edge; the
// output register loads from the queue head when the output is free. Words
// that only open an escape produce nothing.
// in_stall rises only when the bundle queue is full; out_stall holds the
// output register and the queue fills behind it.
// Reset clears the escape phase, the queue and the output valid; no clearing
// pass is needed.
module backslash_hex_escape_decoder
  import bhed_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);

  bundle_t push_data, head;
  logic    push, full, pop, head_valid;

  // Front: classify each byte and build the results it causes.
  bhed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  // Hold bundles so front and back stall independently.
  bhed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: drain one byte per cycle into the output register while out_stall is low.
  bhed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule
